[rtl/core/slab_pkg.sv]
// Shared types and constants for the seam linear alpha blend pipeline.
`default_nettype none

package slab_pkg;

  localparam int COL_W         = 12;
  localparam int LW_W          = 13;
  localparam int PIX_W         = 8;
  localparam int FRAC_W        = 16;
  localparam int ALPHA_W       = FRAC_W + 1;
  localparam int PROD_W        = PIX_W + ALPHA_W;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int LW_RESET      = 4096;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << FRAC_W;
  localparam logic [ALPHA_W-1:0] ALPHA_ZERO = '0;

  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_BLEND = 2'd1,
    REGION_WARP  = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    MODE_ONE  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_DIV  = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_OVERLAP_START = 1'b0,
    CFG_LEFT_WIDTH    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] overlap_start;
    logic [LW_W-1:0]  left_width;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] l0;
    logic [PIX_W-1:0] l1;
    logic [PIX_W-1:0] l2;
    logic [PIX_W-1:0] w0;
    logic [PIX_W-1:0] w1;
    logic [PIX_W-1:0] w2;
    region_t          region;
  } pix_t;

  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic [LW_W-1:0]   rem;
    logic [LW_W-1:0]   span;
    logic [FRAC_W-1:0] quo;
    pix_t              pix;
  } div_t;

  typedef struct packed {
    logic               valid;
    logic [ALPHA_W-1:0] alpha;
    pix_t               pix;
  } blend_t;

endpackage

`default_nettype wire

[rtl/core/seam_linear_alpha_blend_top.sv]
// Top level of the seam linear alpha blend pipeline.
//
//   channel   handshake                      payload
//   config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//   pixel in  start & !busy                  column, left_ch0..2, warp_ch0..2
//   pixel out done (one-cycle strobe)        out_ch0..2, region
//
// One pixel beat per clock; busy is held low, start may be high every cycle.
// done rises with the result beat after input capture, classification, 16 divider
// stages and two blend stages.
// rst is synchronous; it clears all valid bits and loads the register defaults.
// Results cannot be stalled; each beat shows on the outputs for one cycle.
`default_nettype none

module seam_linear_alpha_blend_top
  import slab_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [COL_W-1:0]  column,
  input  logic [PIX_W-1:0]  left_ch0,
  input  logic [PIX_W-1:0]  left_ch1,
  input  logic [PIX_W-1:0]  left_ch2,
  input  logic [PIX_W-1:0]  warp_ch0,
  input  logic [PIX_W-1:0]  warp_ch1,
  input  logic [PIX_W-1:0]  warp_ch2,
  output logic              done,
  output logic [PIX_W-1:0]  out_ch0,
  output logic [PIX_W-1:0]  out_ch1,
  output logic [PIX_W-1:0]  out_ch2,
  output logic [1:0]        region
);

  cfg_t   cfg;
  div_t   front_out;
  blend_t div_out;

  assign busy = 1'b0;

  slab_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slab_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start & ~busy),
    .column   (column),
    .left_ch0 (left_ch0),
    .left_ch1 (left_ch1),
    .left_ch2 (left_ch2),
    .warp_ch0 (warp_ch0),
    .warp_ch1 (warp_ch1),
    .warp_ch2 (warp_ch2),
    .out      (front_out)
  );

  slab_div u_div (
    .clk (clk),
    .rst (rst),
    .in  (front_out),
    .out (div_out)
  );

  slab_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .in      (div_out),
    .done    (done),
    .out_ch0 (out_ch0),
    .out_ch1 (out_ch1),
    .out_ch2 (out_ch2),
    .region  (region)
  );

endmodule

`default_nettype wire

[rtl/core/slab_regs.sv]
// APB configuration registers: overlap start and left image width.
`default_nettype none

module slab_regs
  import slab_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam int LW_FULL = (1 << LW_W) - 1;
  localparam int LW_CAP  = (MAX_WIDTH > LW_FULL) ? LW_FULL : MAX_WIDTH;
  localparam logic [LW_W-1:0] LW_MAX  = LW_W'(LW_CAP);
  localparam logic [LW_W-1:0] LW_INIT = LW_W'((MAX_WIDTH < LW_RESET) ? MAX_WIDTH : LW_RESET);

  cfg_idx_t        idx;
  logic            wr;
  logic [LW_W-1:0] lw_wdata;

  assign idx      = cfg_idx_t'(paddr[2]);
  assign wr       = psel & penable & pwrite;
  assign lw_wdata = pwdata[LW_W-1:0];
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overlap_start <= '0;
      cfg.left_width    <= LW_INIT;
    end else if (wr) begin
      case (idx)
        CFG_OVERLAP_START: cfg.overlap_start <= pwdata[COL_W-1:0];
        CFG_LEFT_WIDTH:    cfg.left_width    <= (lw_wdata > LW_MAX) ? LW_MAX : lw_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_OVERLAP_START: prdata = DATA_W'(cfg.overlap_start);
      CFG_LEFT_WIDTH:    prdata = DATA_W'(cfg.left_width);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/slab_front.sv]
// Input capture and region classification; sets up the alpha division.
`default_nettype none

module slab_front
  import slab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             start,
  input  logic [COL_W-1:0] column,
  input  logic [PIX_W-1:0] left_ch0,
  input  logic [PIX_W-1:0] left_ch1,
  input  logic [PIX_W-1:0] left_ch2,
  input  logic [PIX_W-1:0] warp_ch0,
  input  logic [PIX_W-1:0] warp_ch1,
  input  logic [PIX_W-1:0] warp_ch2,
  output div_t             out
);

  logic             a_valid;
  logic [COL_W-1:0] a_col;
  pix_t             a_pix;
  div_t             out_next;

  logic [LW_W-1:0]  col_ext;
  logic [LW_W-1:0]  num;
  logic [LW_W-1:0]  span;
  logic             in_left;
  logic             in_warp;
  logic             warp_zero;

  always_ff @(posedge clk) begin
    a_valid <= start;
    a_col   <= column;
    a_pix   <= '{l0: left_ch0, l1: left_ch1, l2: left_ch2,
                 w0: warp_ch0, w1: warp_ch1, w2: warp_ch2, region: REGION_LEFT};
    if (rst) begin
      a_valid <= 1'b0;
    end
  end

  assign col_ext   = LW_W'(a_col);
  assign num       = cfg.left_width - col_ext;
  assign span      = cfg.left_width - LW_W'(cfg.overlap_start);
  assign in_warp   = col_ext >= cfg.left_width;
  assign in_left   = (a_col < cfg.overlap_start) && !in_warp;
  assign warp_zero = (a_pix.w0 == '0) && (a_pix.w1 == '0) && (a_pix.w2 == '0);

  always_comb begin
    out_next       = '0;
    out_next.valid = a_valid;
    out_next.span  = span;
    out_next.pix   = a_pix;
    if (in_warp) begin
      out_next.pix.region = REGION_WARP;
      out_next.mode       = MODE_ZERO;
    end else if (in_left) begin
      out_next.pix.region = REGION_LEFT;
      out_next.mode       = MODE_ONE;
    end else begin
      out_next.pix.region = REGION_BLEND;
      if (warp_zero || (num == span)) begin
        out_next.mode = MODE_ONE;
      end else begin
        out_next.mode = MODE_DIV;
        out_next.rem  = num;
      end
    end
  end

  always_ff @(posedge clk) begin
    out <= out_next;
    if (rst) begin
      out.valid <= 1'b0;
    end
  end

  // fraction must start proper: 0 < rem < span
  a_div_setup: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.mode == MODE_DIV) |-> (out.rem != '0 && out.rem < out.span))
    else $error("divider setup out of range");

endmodule

`default_nettype wire

[rtl/core/slab_div.sv]
// Pipelined restoring fraction divider, one quotient bit per stage.
`default_nettype none

module slab_div
  import slab_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  div_t   in,
  output blend_t out
);

  div_t st [FRAC_W];
  div_t last;

  function automatic div_t div_step(div_t s);
    logic [LW_W:0] dbl;
    logic [LW_W:0] diff;
    div_t          r;
    dbl  = {s.rem, 1'b0};
    diff = dbl - {1'b0, s.span};
    r    = s;
    if (s.mode == MODE_DIV) begin
      if (dbl >= {1'b0, s.span}) begin
        r.rem = diff[LW_W-1:0];
        r.quo = {s.quo[FRAC_W-2:0], 1'b1};
      end else begin
        r.rem = dbl[LW_W-1:0];
        r.quo = {s.quo[FRAC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    st[0] <= div_step(in);
    if (rst) begin
      st[0].valid <= 1'b0;
    end
  end

  for (genvar k = 1; k < FRAC_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st[k] <= div_step(st[k-1]);
      if (rst) begin
        st[k].valid <= 1'b0;
      end
    end
  end

  assign last = st[FRAC_W-1];

  always_comb begin
    out.valid = last.valid;
    out.pix   = last.pix;
    case (last.mode)
      MODE_ONE:  out.alpha = ALPHA_ONE;
      MODE_ZERO: out.alpha = ALPHA_ZERO;
      MODE_DIV:  out.alpha = ALPHA_W'(last.quo);
      default:   out.alpha = ALPHA_ZERO;
    endcase
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (last.valid && last.mode == MODE_DIV) |-> (last.rem < last.span))
    else $error("divider remainder not below span");

endmodule

`default_nettype wire

[rtl/core/slab_mix.sv]
// Per-channel cross-fade: two products per channel, then sum and truncate.
`default_nettype none

module slab_mix
  import slab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  blend_t           in,
  output logic             done,
  output logic [PIX_W-1:0] out_ch0,
  output logic [PIX_W-1:0] out_ch1,
  output logic [PIX_W-1:0] out_ch2,
  output logic [1:0]       region
);

  logic [ALPHA_W-1:0] inv;
  logic [PIX_W-1:0]   lch [3];
  logic [PIX_W-1:0]   wch [3];
  logic [PROD_W-1:0]  pl_next [3];
  logic [PROD_W-1:0]  pw_next [3];

  logic               v1;
  region_t            region1;
  logic [PROD_W-1:0]  pl [3];
  logic [PROD_W-1:0]  pw [3];
  logic [PROD_W:0]    sum [3];

  assign inv    = ALPHA_ONE - in.alpha;
  assign lch[0] = in.pix.l0;
  assign lch[1] = in.pix.l1;
  assign lch[2] = in.pix.l2;
  assign wch[0] = in.pix.w0;
  assign wch[1] = in.pix.w1;
  assign wch[2] = in.pix.w2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_next[k] = PROD_W'(lch[k]) * PROD_W'(in.alpha);
      pw_next[k] = PROD_W'(wch[k]) * PROD_W'(inv);
    end
  end

  always_ff @(posedge clk) begin
    v1      <= in.valid;
    region1 <= in.pix.region;
    pl      <= pl_next;
    pw      <= pw_next;
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = {1'b0, pl[k]} + {1'b0, pw[k]};
    end
  end

  always_ff @(posedge clk) begin
    done    <= v1;
    out_ch0 <= sum[0][FRAC_W+PIX_W-1:FRAC_W];
    out_ch1 <= sum[1][FRAC_W+PIX_W-1:FRAC_W];
    out_ch2 <= sum[2][FRAC_W+PIX_W-1:FRAC_W];
    region  <= region1;
    if (rst) begin
      done <= 1'b0;
    end
  end

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    in.valid |-> (in.alpha <= ALPHA_ONE))
    else $error("alpha above one");

  a_sum_fits: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (sum[0][PROD_W:FRAC_W+PIX_W] == '0 && sum[1][PROD_W:FRAC_W+PIX_W] == '0
            && sum[2][PROD_W:FRAC_W+PIX_W] == '0))
    else $error("blend sum exceeds pixel range");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    v1 |=> done)
    else $error("blend beat lost");

endmodule

`default_nettype wire
